// File: rtl/bmrle_pkg.sv
// ----------------------------------------------------------------------------
// bmrle_pkg
// Shared types and constants of the bitmap run-length scanline decoder:
// field widths, register indexes, command kinds, parse phases, result beat.
// ----------------------------------------------------------------------------
package bmrle_pkg;

  // field widths
  localparam int ADDR_BITS  = 32;
  localparam int LINE_W     = 18;
  localparam int STRIDE_W   = 18;
  localparam int PLANES_W   = 4;
  localparam int HEIGHT_W   = 16;
  localparam int PLEN_W     = 4;
  localparam int CNT_W      = 11;
  localparam int PAT_W      = 64;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 18;

  localparam int MAX_PATTERN = 8;
  localparam int MAX_PLANES  = 8;

  localparam logic [LINE_W-1:0] COL_MAX = {LINE_W{1'b1}};

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINE_BYTES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_STRIDE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PLANE_COUNT    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd4;

  // command kinds
  localparam logic [1:0] CMD_LITERAL = 2'd0;
  localparam logic [1:0] CMD_FILL    = 2'd1;
  localparam logic [1:0] CMD_PATTERN = 2'd2;
  localparam logic [1:0] CMD_COPY    = 2'd3;

  // stream byte codes
  localparam logic [7:0] BYTE_ZERO   = 8'h00;
  localparam logic [7:0] BYTE_FF     = 8'hff;
  localparam logic [7:0] BYTE_LIT    = 8'h80;
  localparam logic [7:0] RUN_MASK    = 8'h7f;

  // parse phases
  localparam logic [3:0] PH_HDR0   = 4'd0;
  localparam logic [3:0] PH_HDR1   = 4'd1;
  localparam logic [3:0] PH_HDR2   = 4'd2;
  localparam logic [3:0] PH_VRC    = 4'd3;
  localparam logic [3:0] PH_OP     = 4'd4;
  localparam logic [3:0] PH_PCOUNT = 4'd5;
  localparam logic [3:0] PH_PDATA  = 4'd6;
  localparam logic [3:0] PH_LCOUNT = 4'd7;
  localparam logic [3:0] PH_LDATA  = 4'd8;

  typedef struct packed {
    logic [LINE_W-1:0]   line_bytes;
    logic [STRIDE_W-1:0] row_stride;
    logic [PLANES_W-1:0] plane_count;
    logic [HEIGHT_W-1:0] image_height;
    logic [PLEN_W-1:0]   pattern_length;
  } cfg_t;

  typedef struct packed {
    logic [1:0]           cmd_kind;
    logic [ADDR_BITS-1:0] dest_addr;
    logic [ADDR_BITS-1:0] source_addr;
    logic [CNT_W-1:0]     byte_count;
    logic [7:0]           fill_value;
    logic [PAT_W-1:0]     pattern_data;
    logic                 image_done;
    logic                 last_result;
  } res_t;

endpackage

// File: rtl/bmrle_dec.sv
// ----------------------------------------------------------------------------
// bmrle_dec
// Parse state and combinational decode of one compressed byte into up to two
// frame store commands (the byte's own command, then a line copy).
// ----------------------------------------------------------------------------
module bmrle_dec (
  input  logic             clk,
  input  logic             rst_n,
  input  bmrle_pkg::cfg_t  cfg,
  input  logic             step,
  input  logic [7:0]       stream_byte,
  input  logic             frame_start,
  output logic [1:0]       nres,
  output bmrle_pkg::res_t  res0,
  output bmrle_pkg::res_t  res1
);
  import bmrle_pkg::*;

  // state registers
  logic [3:0]           ph_r, ph_nxt;
  logic [LINE_W-1:0]    col_r, col_nxt;
  logic [HEIGHT_W-1:0]  row_r, row_nxt;
  logic [2:0]           pln_r, pln_nxt;
  logic [7:0]           rep_r, rep_nxt;
  logic [7:0]           run_r, run_nxt;
  logic [PAT_W-1:0]     pst_r, pst_nxt;
  logic [3:0]           pidx_r, pidx_nxt;
  logic [ADDR_BITS-1:0] base_r, base_nxt;
  logic [ADDR_BITS-1:0] cur_r, cur_nxt;
  logic                 fin_r, fin_nxt;

  // decode working signals
  logic                 do_op, do_pat, chk, emit_c, emit_cp;
  res_t                 cmd_res, copy_res;
  logic [CNT_W-1:0]     adv_n;
  logic [PLEN_W-1:0]    plen, npl;
  logic [11:0]          n_pat;
  logic [LINE_W:0]      col_sum;
  logic [HEIGHT_W:0]    y1, avail, rsum;
  logic [7:0]           copies;
  logic [PLANES_W-1:0]  pln_inc;
  logic [18:0]          pterm, key;
  logic [36:0]          prod;

  // effective plane count and pattern length
  always_comb begin
    if (cfg.plane_count == '0) npl = PLANES_W'(1);
    else if (cfg.plane_count > PLANES_W'(MAX_PLANES)) npl = PLANES_W'(MAX_PLANES);
    else npl = cfg.plane_count;
    if (cfg.pattern_length == '0) plen = PLEN_W'(1);
    else if (cfg.pattern_length > PLEN_W'(MAX_PATTERN)) plen = PLEN_W'(MAX_PATTERN);
    else plen = cfg.pattern_length;
  end

  // byte decode
  always_comb begin
    ph_nxt   = ph_r;
    col_nxt  = col_r;
    row_nxt  = row_r;
    pln_nxt  = pln_r;
    rep_nxt  = rep_r;
    run_nxt  = run_r;
    pst_nxt  = pst_r;
    pidx_nxt = pidx_r;
    base_nxt = base_r;
    cur_nxt  = cur_r;
    fin_nxt  = fin_r;
    do_op    = 1'b0;
    do_pat   = 1'b0;
    chk      = 1'b0;
    emit_c   = 1'b0;
    emit_cp  = 1'b0;
    cmd_res  = '0;
    copy_res = '0;
    adv_n    = '0;
    n_pat    = '0;
    col_sum  = '0;
    y1       = '0;
    avail    = '0;
    rsum     = '0;
    copies   = '0;
    pln_inc  = '0;
    pterm    = '0;
    key      = '0;
    prod     = '0;

    // frame start restarts everything but the registers
    if (frame_start) begin
      ph_nxt   = PH_HDR0;
      col_nxt  = '0;
      row_nxt  = '0;
      pln_nxt  = '0;
      rep_nxt  = 8'd1;
      run_nxt  = '0;
      pst_nxt  = '0;
      pidx_nxt = '0;
      base_nxt = '0;
      cur_nxt  = '0;
      fin_nxt  = 1'b0;
    end

    if (!fin_nxt) begin
      // parse phase dispatch
      unique case (ph_nxt)
        PH_HDR0: begin
          if (stream_byte == BYTE_ZERO) ph_nxt = PH_HDR1;
          else do_op = 1'b1;
        end
        PH_HDR1: begin
          if (stream_byte == BYTE_ZERO) ph_nxt = PH_HDR2;
          else begin
            run_nxt  = stream_byte;
            pst_nxt  = '0;
            pidx_nxt = '0;
            ph_nxt   = PH_PDATA;
          end
        end
        PH_HDR2: begin
          if (stream_byte == BYTE_FF) ph_nxt = PH_VRC;
          else begin
            run_nxt  = '0;
            pst_nxt  = '0;
            pidx_nxt = '0;
            do_pat   = 1'b1;
          end
        end
        PH_VRC: begin
          rep_nxt = stream_byte;
          ph_nxt  = PH_OP;
        end
        PH_OP: do_op = 1'b1;
        PH_PCOUNT: begin
          run_nxt  = stream_byte;
          pst_nxt  = '0;
          pidx_nxt = '0;
          ph_nxt   = PH_PDATA;
        end
        PH_PDATA: do_pat = 1'b1;
        PH_LCOUNT: begin
          run_nxt = stream_byte;
          if (stream_byte == BYTE_ZERO) begin
            ph_nxt = PH_OP;
            chk    = 1'b1;
          end else begin
            ph_nxt = PH_LDATA;
          end
        end
        default: begin
          // literal string byte
          emit_c               = 1'b1;
          cmd_res.cmd_kind     = CMD_LITERAL;
          cmd_res.dest_addr    = cur_nxt;
          cmd_res.byte_count   = CNT_W'(1);
          cmd_res.fill_value   = stream_byte;
          adv_n                = CNT_W'(1);
          run_nxt              = run_nxt - 8'd1;
          if (run_nxt == '0) begin
            ph_nxt = PH_OP;
            chk    = 1'b1;
          end
        end
      endcase

      // opcode byte: pattern, literal string or solid fill
      if (do_op) begin
        if (stream_byte == BYTE_ZERO) ph_nxt = PH_PCOUNT;
        else if (stream_byte == BYTE_LIT) ph_nxt = PH_LCOUNT;
        else begin
          emit_c             = 1'b1;
          cmd_res.cmd_kind   = CMD_FILL;
          cmd_res.dest_addr  = cur_nxt;
          cmd_res.byte_count = CNT_W'(stream_byte & RUN_MASK);
          cmd_res.fill_value = (stream_byte > BYTE_LIT) ? BYTE_FF : BYTE_ZERO;
          adv_n              = CNT_W'(stream_byte & RUN_MASK);
          ph_nxt             = PH_OP;
          chk                = 1'b1;
        end
      end

      // pattern data byte
      if (do_pat) begin
        pst_nxt  = pst_nxt | (PAT_W'(stream_byte) << {pidx_nxt[2:0], 3'b000});
        pidx_nxt = pidx_nxt + 4'd1;
        ph_nxt   = PH_PDATA;
        if (pidx_nxt >= plen) begin
          n_pat = {4'b0, run_nxt} * {8'b0, plen};
          if (n_pat != '0) begin
            emit_c               = 1'b1;
            cmd_res.cmd_kind     = CMD_PATTERN;
            cmd_res.dest_addr    = cur_nxt;
            cmd_res.byte_count   = n_pat[CNT_W-1:0];
            cmd_res.pattern_data = pst_nxt;
          end
          adv_n  = n_pat[CNT_W-1:0];
          ph_nxt = PH_OP;
          chk    = 1'b1;
        end
      end

      // advance column and cursor
      col_sum = {1'b0, col_nxt} + (LINE_W+1)'(adv_n);
      col_nxt = (col_sum > {1'b0, COL_MAX}) ? COL_MAX : col_sum[LINE_W-1:0];
      cur_nxt = cur_nxt + ADDR_BITS'(adv_n);

      // line end: replicate, step plane or row, rebase
      if (chk && (col_nxt >= cfg.line_bytes)) begin
        y1     = {1'b0, row_nxt} + (HEIGHT_W+1)'(1);
        avail  = (y1 < {1'b0, cfg.image_height}) ? ({1'b0, cfg.image_height} - y1) : '0;
        copies = (rep_nxt != '0) ? (rep_nxt - 8'd1) : '0;
        if ({9'b0, copies} > avail) copies = avail[7:0];
        if (copies != '0) begin
          emit_cp              = 1'b1;
          copy_res.cmd_kind    = CMD_COPY;
          copy_res.dest_addr   = base_nxt + ADDR_BITS'(cfg.row_stride);
          copy_res.source_addr = base_nxt;
          copy_res.byte_count  = CNT_W'(copies);
        end
        pln_inc = {1'b0, pln_nxt} + PLANES_W'(1);
        if (pln_inc >= npl) begin
          pln_nxt = '0;
          rsum    = {1'b0, row_nxt} + (HEIGHT_W+1)'(rep_nxt);
          if (rsum >= {1'b0, cfg.image_height}) begin
            rsum    = {1'b0, cfg.image_height};
            fin_nxt = 1'b1;
          end
          row_nxt = rsum[HEIGHT_W-1:0];
          rep_nxt = 8'd1;
        end else begin
          pln_nxt = pln_inc[2:0];
        end
        // base = (plane * height + row) * stride
        pterm    = (pln_nxt[0] ? {3'b0, cfg.image_height}        : 19'd0)
                 + (pln_nxt[1] ? {2'b0, cfg.image_height, 1'b0}  : 19'd0)
                 + (pln_nxt[2] ? {1'b0, cfg.image_height, 2'b0}  : 19'd0);
        key      = pterm + {3'b0, row_nxt};
        prod     = {18'b0, key} * {19'b0, cfg.row_stride};
        base_nxt = prod[ADDR_BITS-1:0];
        cur_nxt  = base_nxt;
        col_nxt  = '0;
        ph_nxt   = PH_HDR0;
      end
    end
  end

  // result beats of this byte
  always_comb begin
    nres = {1'b0, emit_c} + {1'b0, emit_cp};
    res0 = emit_c ? cmd_res : copy_res;
    res0.image_done  = fin_nxt;
    res0.last_result = !(emit_c && emit_cp);
    res1 = copy_res;
    res1.image_done  = fin_nxt;
    res1.last_result = 1'b1;
  end

  // state update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r   <= PH_HDR0;
      col_r  <= '0;
      row_r  <= '0;
      pln_r  <= '0;
      rep_r  <= 8'd1;
      run_r  <= '0;
      pst_r  <= '0;
      pidx_r <= '0;
      base_r <= '0;
      cur_r  <= '0;
      fin_r  <= 1'b0;
    end else if (step) begin
      ph_r   <= ph_nxt;
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      pln_r  <= pln_nxt;
      rep_r  <= rep_nxt;
      run_r  <= run_nxt;
      pst_r  <= pst_nxt;
      pidx_r <= pidx_nxt;
      base_r <= base_nxt;
      cur_r  <= cur_nxt;
      fin_r  <= fin_nxt;
    end
  end

endmodule

// File: rtl/bitmap_rle_scanline_decoder_core.sv
// Decodes a run-length compressed bitmap stream into frame store write
// commands at one byte per clock while the result queue has room. Each
// accepted byte is held in the input register, where it is decoded in a
// single pass and its commands (none, one, or a command plus a line copy at
// the end of a line) go into a four-entry result queue that drains one beat
// per clock while out_stall is low. A byte is taken every cycle as long as
// the queue has room for two beats. Configuration writes are always taken;
// there is no clearing pass after reset.
// ----------------------------------------------------------------------------
// bitmap_rle_scanline_decoder_core
// Top level: configuration registers, input register, decoder and result
// queue of the bitmap run-length scanline decoder.
// ----------------------------------------------------------------------------
module bitmap_rle_scanline_decoder_core (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bmrle_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bmrle_pkg::CFG_DATA_W-1:0]    cfg_data,
  // compressed byte input
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [7:0]                          in_stream_byte,
  input  logic                                in_frame_start,
  // command output
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          out_cmd_kind,
  output logic [bmrle_pkg::ADDR_BITS-1:0]     out_dest_addr,
  output logic [bmrle_pkg::ADDR_BITS-1:0]     out_source_addr,
  output logic [bmrle_pkg::CNT_W-1:0]         out_byte_count,
  output logic [7:0]                          out_fill_value,
  output logic [bmrle_pkg::PAT_W-1:0]         out_pattern_data,
  output logic                                out_image_done,
  output logic                                out_last_result
);
  import bmrle_pkg::*;

  cfg_t        cfg_r;
  logic        in_vld_r;
  logic [7:0]  in_byte_r;
  logic        in_fs_r;
  logic        room, step, pop, in_acc;
  logic [1:0]  nres;
  res_t        dres0, dres1, head;
  res_t        q_r [4];
  logic [1:0]  wptr_r, rptr_r;
  logic [2:0]  cnt_r;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.line_bytes     <= LINE_W'(1);
      cfg_r.row_stride     <= STRIDE_W'(1);
      cfg_r.plane_count    <= PLANES_W'(1);
      cfg_r.image_height   <= HEIGHT_W'(1);
      cfg_r.pattern_length <= PLEN_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_LINE_BYTES:     cfg_r.line_bytes     <= cfg_data[LINE_W-1:0];
        CFG_ROW_STRIDE:     cfg_r.row_stride     <= cfg_data[STRIDE_W-1:0];
        CFG_PLANE_COUNT:    cfg_r.plane_count    <= cfg_data[PLANES_W-1:0];
        CFG_IMAGE_HEIGHT:   cfg_r.image_height   <= cfg_data[HEIGHT_W-1:0];
        CFG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data[PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // queue handshake
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign room      = (cnt_r <= 3'd2) || ((cnt_r == 3'd3) && pop);
  assign step      = in_vld_r && room;
  assign in_stall  = in_vld_r && !room;
  assign in_acc    = in_valid && !in_stall;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_acc) begin
      in_vld_r <= 1'b1;
    end else if (step) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_stream_byte;
      in_fs_r   <= in_frame_start;
    end
  end

  bmrle_dec u_dec (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .step        (step),
    .stream_byte (in_byte_r),
    .frame_start (in_fs_r),
    .nres        (nres),
    .res0        (dres0),
    .res1        (dres1)
  );

  // result queue storage
  always_ff @(posedge clk) begin
    if (step && (nres != 2'd0)) q_r[wptr_r] <= dres0;
    if (step && (nres == 2'd2)) q_r[wptr_r + 2'd1] <= dres1;
  end

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (step) wptr_r <= wptr_r + nres;
      if (pop) rptr_r <= rptr_r + 2'd1;
      cnt_r <= cnt_r + (step ? {1'b0, nres} : 3'd0) - {2'b0, pop};
    end
  end

  // output beat
  assign head             = q_r[rptr_r];
  assign out_cmd_kind     = head.cmd_kind;
  assign out_dest_addr    = head.dest_addr;
  assign out_source_addr  = head.source_addr;
  assign out_byte_count   = head.byte_count;
  assign out_fill_value   = head.fill_value;
  assign out_pattern_data = head.pattern_data;
  assign out_image_done   = head.image_done;
  assign out_last_result  = head.last_result;

endmodule

// File: sim/bitmap_rle_scanline_decoder_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_rle_scanline_decoder_core_tb
// Self-checking bench for the run-length scanline decoder. A scoreboard class
// predicts the frame store commands of every accepted stream byte and checks
// each command beat against them. The bench drives directed header, run and
// clamp cases, then image streams with random content under several register
// settings and random idling on both channels.
// ----------------------------------------------------------------------------
module bitmap_rle_scanline_decoder_core_tb;
  import bmrle_pkg::*;

  class rle_cmd_scoreboard;
    // register copies
    logic [LINE_W-1:0]   line_bytes;
    logic [STRIDE_W-1:0] row_stride;
    logic [PLANES_W-1:0] plane_count;
    logic [HEIGHT_W-1:0] image_height;
    logic [PLEN_W-1:0]   pattern_length;

    // decoder state
    logic [3:0]          phase;
    logic [LINE_W-1:0]   column;
    logic [HEIGHT_W-1:0] row;
    int unsigned         plane;
    logic [7:0]          repl;
    logic [7:0]          run_len;
    logic [PAT_W-1:0]    pattern;
    int unsigned         fill_idx;
    logic [31:0]         row_base;
    logic [31:0]         cursor;
    bit                  finished;

    res_t step_cmds[$];
    res_t expected_cmds[$];
    int   fails;

    function new();
      line_bytes     = LINE_W'(1);
      row_stride     = STRIDE_W'(1);
      plane_count    = PLANES_W'(1);
      image_height   = HEIGHT_W'(1);
      pattern_length = PLEN_W'(1);
      fails          = 0;
      restart();
    endfunction

    function void restart();
      phase    = PH_HDR0;
      column   = '0;
      row      = '0;
      plane    = 0;
      repl     = 8'd1;
      run_len  = '0;
      fill_idx = 0;
      pattern  = '0;
      row_base = '0;
      cursor   = '0;
      finished = 1'b0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_LINE_BYTES:     line_bytes     = data[LINE_W-1:0];
        CFG_ROW_STRIDE:     row_stride     = data[STRIDE_W-1:0];
        CFG_PLANE_COUNT:    plane_count    = data[PLANES_W-1:0];
        CFG_IMAGE_HEIGHT:   image_height   = data[HEIGHT_W-1:0];
        CFG_PATTERN_LENGTH: pattern_length = data[PLEN_W-1:0];
        default: ;
      endcase
    endfunction

    function int unsigned eff_planes();
      if (plane_count == 0) return 1;
      return (plane_count > MAX_PLANES) ? MAX_PLANES : plane_count;
    endfunction

    function int unsigned eff_plen();
      if (pattern_length == 0) return 1;
      return (pattern_length > MAX_PATTERN) ? MAX_PATTERN : pattern_length;
    endfunction

    // at most two commands per byte
    function void push_cmd(logic [1:0] kind, logic [31:0] dest, logic [31:0] src,
                           int unsigned cnt, logic [7:0] fill, logic [PAT_W-1:0] pat);
      res_t c;
      if (step_cmds.size() >= 2) return;
      c.cmd_kind     = kind;
      c.dest_addr    = dest;
      c.source_addr  = src;
      c.byte_count   = CNT_W'(cnt);
      c.fill_value   = fill;
      c.pattern_data = pat;
      c.image_done   = 1'b0;
      c.last_result  = 1'b0;
      step_cmds.push_back(c);
    endfunction

    // start address of the current plane line
    function void set_base();
      logic [63:0] plane_size;
      plane_size = 64'(image_height) * 64'(row_stride);
      row_base   = 32'(plane_size * 64'(plane) + 64'(row) * 64'(row_stride));
      cursor     = row_base;
    endfunction

    function void advance(int unsigned n);
      int unsigned c;
      c      = column + n;
      column = (c > COL_MAX) ? COL_MAX : c[LINE_W-1:0];
      cursor = cursor + n;
    endfunction

    // line end: replicate the row, then move to the next plane or row
    function void end_of_line();
      int unsigned h, y, avail, copies, r;
      h = image_height;
      y = row;
      if (column < line_bytes) return;
      avail  = (y + 1 < h) ? h - y - 1 : 0;
      copies = (repl > 0) ? repl - 1 : 0;
      if (copies > avail) copies = avail;
      if (copies > 0) push_cmd(CMD_COPY, row_base + row_stride, row_base, copies, '0, '0);
      plane++;
      if (plane >= eff_planes()) begin
        plane = 0;
        r = y + repl;
        if (r >= h) begin
          r        = h;
          finished = 1'b1;
        end
        row  = r[HEIGHT_W-1:0];
        repl = 8'd1;
      end
      set_base();
      column = '0;
      phase  = PH_HDR0;
    endfunction

    function void start_pattern(logic [7:0] cnt);
      run_len  = cnt;
      pattern  = '0;
      fill_idx = 0;
      phase    = PH_PDATA;
    endfunction

    function void pattern_in(logic [7:0] b);
      int unsigned plen, n;
      plen     = eff_plen();
      pattern  = pattern | (64'(b) << (8 * (fill_idx & 7)));
      fill_idx = fill_idx + 1;
      phase    = PH_PDATA;
      if (fill_idx < plen) return;
      n = run_len * plen;
      if (n > 0) push_cmd(CMD_PATTERN, cursor, '0, n, '0, pattern);
      advance(n);
      phase = PH_OP;
      end_of_line();
    endfunction

    function void op_in(logic [7:0] b);
      int unsigned n;
      if (b == BYTE_ZERO) begin
        phase = PH_PCOUNT;
        return;
      end
      if (b == BYTE_LIT) begin
        phase = PH_LCOUNT;
        return;
      end
      n = b & RUN_MASK;
      push_cmd(CMD_FILL, cursor, '0, n, (b > BYTE_LIT) ? BYTE_FF : BYTE_ZERO, '0);
      advance(n);
      phase = PH_OP;
      end_of_line();
    endfunction

    function void decode_byte(logic [7:0] b);
      case (phase)
        PH_HDR0: begin
          if (b == BYTE_ZERO) phase = PH_HDR1;
          else op_in(b);
        end
        PH_HDR1: begin
          if (b == BYTE_ZERO) phase = PH_HDR2;
          else start_pattern(b);
        end
        PH_HDR2: begin
          if (b == BYTE_FF) begin
            phase = PH_VRC;
          end else begin
            start_pattern('0);
            pattern_in(b);
          end
        end
        PH_VRC: begin
          repl  = b;
          phase = PH_OP;
        end
        PH_OP:     op_in(b);
        PH_PCOUNT: start_pattern(b);
        PH_PDATA:  pattern_in(b);
        PH_LCOUNT: begin
          run_len = b;
          if (b == BYTE_ZERO) begin
            phase = PH_OP;
            end_of_line();
          end else begin
            phase = PH_LDATA;
          end
        end
        default: begin
          push_cmd(CMD_LITERAL, cursor, '0, 1, b, '0);
          advance(1);
          run_len = run_len - 8'd1;
          if (run_len == 0) begin
            phase = PH_OP;
            end_of_line();
          end
        end
      endcase
    endfunction

    // accepted input beat: queue the commands it causes
    function void note_byte(logic [7:0] b, logic frame_start);
      step_cmds.delete();
      if (frame_start) restart();
      if (!finished) decode_byte(b);
      foreach (step_cmds[k]) begin
        step_cmds[k].image_done  = finished;
        step_cmds[k].last_result = (k == step_cmds.size() - 1);
        expected_cmds.push_back(step_cmds[k]);
      end
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %h, got %h", name, want, got);
        fails++;
      end
    endfunction

    // accepted command beat: compare with the oldest expected command
    function void check_cmd(res_t got);
      res_t want;
      if (expected_cmds.size() == 0) begin
        $error("command beat with nothing expected: kind %0d dest %h",
               got.cmd_kind, got.dest_addr);
        fails++;
        return;
      end
      want = expected_cmds.pop_front();
      compare_field("cmd_kind", want.cmd_kind, got.cmd_kind);
      compare_field("dest_addr", want.dest_addr, got.dest_addr);
      compare_field("source_addr", want.source_addr, got.source_addr);
      compare_field("byte_count", want.byte_count, got.byte_count);
      compare_field("fill_value", want.fill_value, got.fill_value);
      compare_field("pattern_data", want.pattern_data, got.pattern_data);
      compare_field("image_done", want.image_done, got.image_done);
      compare_field("last_result", want.last_result, got.last_result);
    endfunction
  endclass

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int SESSION_BYTES = 36;
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 3'd7;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_valid      = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index      = '0;
  logic [CFG_DATA_W-1:0] cfg_data       = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_stall;
  logic [7:0]            in_stream_byte = '0;
  logic                  in_frame_start = 1'b0;
  logic                  out_valid;
  logic                  out_stall      = 1'b0;
  logic [1:0]            out_cmd_kind;
  logic [ADDR_BITS-1:0]  out_dest_addr;
  logic [ADDR_BITS-1:0]  out_source_addr;
  logic [CNT_W-1:0]      out_byte_count;
  logic [7:0]            out_fill_value;
  logic [PAT_W-1:0]      out_pattern_data;
  logic                  out_image_done;
  logic                  out_last_result;

  rle_cmd_scoreboard sb;
  int          cycle_count   = 0;
  int          send_idle_pct = 7;
  int          recv_idle_pct = 46;
  int          bytes_left;
  bit          frame_flag;
  // stream generator's view of the image
  int unsigned gen_plane, gen_row, gen_repl;
  bit          gen_done;

  bitmap_rle_scanline_decoder_core u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_stream_byte   (in_stream_byte),
    .in_frame_start   (in_frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_cmd_kind     (out_cmd_kind),
    .out_dest_addr    (out_dest_addr),
    .out_source_addr  (out_source_addr),
    .out_byte_count   (out_byte_count),
    .out_fill_value   (out_fill_value),
    .out_pattern_data (out_pattern_data),
    .out_image_done   (out_image_done),
    .out_last_result  (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
  end

  // beat monitor: results, input bytes, register writes
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall)
        sb.check_cmd({out_cmd_kind, out_dest_addr, out_source_addr, out_byte_count,
                      out_fill_value, out_pattern_data, out_image_done, out_last_result});
      if (in_valid && !in_stall) sb.note_byte(in_stream_byte, in_frame_start);
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
    end
  end

  // one input beat; frame_flag marks the first byte of a frame
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_stream_byte <= b;
    in_frame_start <= frame_flag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    frame_flag = 1'b0;
    bytes_left--;
  endtask

  // drain all expected commands, then let the pipeline settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_cmds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic apply_config(input logic [CFG_DATA_W-1:0] lb, input logic [CFG_DATA_W-1:0] stride,
                              input logic [CFG_DATA_W-1:0] planes,
                              input logic [CFG_DATA_W-1:0] height,
                              input logic [CFG_DATA_W-1:0] plen);
    wait_idle();
    write_cfg(CFG_LINE_BYTES, lb);
    write_cfg(CFG_ROW_STRIDE, stride);
    write_cfg(CFG_PLANE_COUNT, planes);
    write_cfg(CFG_IMAGE_HEIGHT, height);
    write_cfg(CFG_PATTERN_LENGTH, plen);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // one plane line: optional replication header, then runs until the line is full
  task automatic send_line();
    int unsigned col, cnt, kind;
    logic [7:0]  b;
    col = 0;
    if ($urandom_range(0, 99) < 60) begin
      kind = $urandom_range(0, 19);
      if (kind < 2) gen_repl = 0;
      else if (kind < 16) gen_repl = $urandom_range(1, 3);
      else gen_repl = $urandom_range(4, 255);
      send_byte(BYTE_ZERO);
      send_byte(BYTE_ZERO);
      send_byte(BYTE_FF);
      send_byte(8'(gen_repl));
    end
    do begin
      kind = $urandom_range(0, 19);
      if (kind < 8) begin
        // fill run, mostly short
        if ($urandom_range(0, 2) != 0) begin
          b = {1'($urandom_range(0, 1)), 7'($urandom_range(1, 8))};
        end else begin
          b = 8'($urandom_range(1, 255));
          if (b == BYTE_LIT) b = BYTE_FF;
        end
        send_byte(b);
        col += b & RUN_MASK;
      end else if (kind < 14) begin
        // pattern run
        cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 3);
        send_byte(BYTE_ZERO);
        send_byte(8'(cnt));
        for (int i = 0; i < sb.eff_plen(); i++) begin
          b = 8'($urandom_range(0, 255));
          if (i == 0 && cnt == 0 && b == BYTE_FF) b = RUN_MASK;
          send_byte(b);
        end
        col += cnt * sb.eff_plen();
      end else if (kind < 19) begin
        // literal string
        cnt = $urandom_range(0, 5);
        send_byte(BYTE_LIT);
        send_byte(8'(cnt));
        repeat (cnt) send_byte(8'($urandom_range(0, 255)));
        col += cnt;
      end else begin
        // stray byte, now and then with a frame restart
        frame_flag = ($urandom_range(0, 7) == 0);
        send_byte(8'($urandom_range(0, 255)));
      end
    end while (col < sb.line_bytes && bytes_left > 0);
    if (col >= sb.line_bytes) begin
      gen_plane++;
      if (gen_plane >= sb.eff_planes()) begin
        gen_plane = 0;
        gen_row  += gen_repl;
        gen_repl  = 1;
        if (gen_row >= sb.image_height) gen_done = 1'b1;
      end
    end
  endtask

  task automatic send_image();
    gen_plane  = 0;
    gen_row    = 0;
    gen_repl   = 1;
    gen_done   = 1'b0;
    frame_flag = 1'b1;
    while (!gen_done && bytes_left > 0) send_line();
    // bytes past the end of the image are dropped
    if (gen_done && $urandom_range(0, 1) == 1) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic run_session(input logic [CFG_DATA_W-1:0] lb, input logic [CFG_DATA_W-1:0] stride,
                             input logic [CFG_DATA_W-1:0] planes,
                             input logic [CFG_DATA_W-1:0] height,
                             input logic [CFG_DATA_W-1:0] plen);
    apply_config(lb, stride, planes, height, plen);
    bytes_left = SESSION_BYTES;
    while (bytes_left > 0) send_image();
  endtask

  task automatic run_random_session();
    run_session(CFG_DATA_W'($urandom_range(1, 24)), CFG_DATA_W'($urandom),
                CFG_DATA_W'($urandom_range(1, 8)), CFG_DATA_W'($urandom_range(1, 6)),
                CFG_DATA_W'($urandom_range(1, 8)));
  endtask

  // header, empty runs, lookalike header, overlong run, zero and clamped replication
  task automatic run_directed();
    apply_config(CFG_DATA_W'(4), CFG_DATA_W'(100), CFG_DATA_W'(2), CFG_DATA_W'(3),
                 CFG_DATA_W'(2));
    frame_flag = 1'b1;
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_FF);
    send_byte(8'd2);
    send_byte(BYTE_LIT);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_LIT | 8'd3);
    send_byte(8'd1);
    // plane 1 opens with a header lookalike: empty pattern run
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(8'h11);
    send_byte(8'h22);
    // pattern run passing the line end, replication carried over
    send_byte(BYTE_ZERO);
    send_byte(8'd3);
    send_byte(8'h5a);
    send_byte(8'ha5);
    // row 2 with replication zero decodes row 2 again
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_FF);
    send_byte(BYTE_ZERO);
    send_byte(RUN_MASK);
    send_byte(BYTE_FF);
    // replication clamped at the last row finishes the image
    send_byte(BYTE_ZERO);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_FF);
    send_byte(8'd9);
    send_byte(BYTE_LIT);
    send_byte(8'd2);
    send_byte(BYTE_ZERO);
    send_byte(BYTE_FF);
    send_byte(BYTE_LIT | 8'd2);
    send_byte(BYTE_LIT | 8'd4);
    send_byte(BYTE_LIT | 8'd5);
    frame_flag = 1'b1;
    send_byte(BYTE_LIT | 8'd3);
    send_byte(8'd1);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // sender mostly busy, receiver stalls often
    send_idle_pct = 7;
    recv_idle_pct = 46;
    run_directed();
    run_random_session();
    run_random_session();
    wait_idle();
    write_cfg(CFG_NO_REG, CFG_DATA_W'($urandom));
    run_session(CFG_DATA_W'(0), CFG_DATA_W'(1), CFG_DATA_W'(0), CFG_DATA_W'(0),
                CFG_DATA_W'(0));

    // sender gaps often, receiver rarely stalls
    send_idle_pct = 46;
    recv_idle_pct = 7;
    run_random_session();
    run_session(CFG_DATA_W'(3), COL_MAX, CFG_DATA_W'(15), CFG_DATA_W'(16'hffff),
                CFG_DATA_W'(15));
    run_session(CFG_DATA_W'(196608), CFG_DATA_W'(196608), CFG_DATA_W'(MAX_PLANES),
                CFG_DATA_W'(16'hffff), CFG_DATA_W'(MAX_PATTERN));

    // back to back
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random_session();
    run_random_session();
    run_random_session();

    wait_idle();
    if (sb.fails == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
